>>> hdl/djk_pkg.sv
// Shared constants, request codes and controller/datapath struct types for the
// dense shortest path block. No dependencies; every other file imports this one.
package djk_pkg;

  localparam int MAX_VERTICES      = 16;
  localparam int INFINITE_DISTANCE = 9999;

  localparam int VERTEX_W   = 4;
  localparam int DIST_W     = 14;
  localparam int VCNT_W     = 5;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int ADDR_W     = 2 * VERTEX_W;
  localparam int MAT_DEPTH  = MAX_VERTICES * MAX_VERTICES;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_CLEAR = 2'd2
  } djk_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_SOURCE       = 2'd1,
    CFG_DESTINATION  = 2'd2
  } djk_cfg_idx_t;

  typedef struct packed {
    logic [VCNT_W-1:0]   vertex_count;
    logic [VERTEX_W-1:0] source_vertex;
    logic [VERTEX_W-1:0] destination_vertex;
  } djk_cfg_t;

  typedef struct packed {
    logic accept;
    logic init;
    logic scan_step;
    logic eval;
    logic relax_issue;
    logic scan_start;
    logic out_load;
  } djk_cmd_t;

  typedef struct packed {
    logic run_req;
    logic n_zero;
    logic idx_last;
    logic found;
    logic out_free;
  } djk_status_t;

endpackage

>>> hdl/djk_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on djk_pkg for field widths.
interface djk_in_if;
  import djk_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [VERTEX_W-1:0] edge_from;
  logic [VERTEX_W-1:0] edge_to;
  logic [DIST_W-1:0]   edge_weight;
  modport source (output valid, req_type, edge_from, edge_to, edge_weight, input ready);
  modport sink   (input valid, req_type, edge_from, edge_to, edge_weight, output ready);
endinterface

interface djk_out_if;
  import djk_pkg::*;
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex;
  logic [DIST_W-1:0]   distance;
  logic                reached;
  logic [VERTEX_W-1:0] predecessor;
  logic                has_predecessor;
  logic                is_destination;
  logic                last;
  modport source (output valid, vertex, distance, reached, predecessor, has_predecessor,
                  is_destination, last, input ready);
  modport sink   (input valid, vertex, distance, reached, predecessor, has_predecessor,
                  is_destination, last, output ready);
endinterface

interface djk_cfg_if;
  import djk_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/djk_ctrl.sv
// Sequencing state machine for the shortest path block: request intake, table
// init, min scan, relax pass and result output. Depends on djk_pkg.
module djk_ctrl import djk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  djk_status_t status,
  output djk_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_RELAX = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.run_req) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = status.n_zero ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.idx_last) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.found ? S_RELAX : S_OUT;
      end
      S_RELAX: begin
        cmd.relax_issue = 1'b1;
        if (status.idx_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.idx_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/djk_dp.sv
// Datapath: edge weight memory with per-entry valid bits, distance/predecessor
// tables, scan and relax arithmetic, and the result register. Depends on djk_pkg.
module djk_dp import djk_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  djk_cmd_t            cmd,
  output djk_status_t         status,
  input  djk_cfg_t            cfg,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [VERTEX_W-1:0] in_edge_from,
  input  logic [VERTEX_W-1:0] in_edge_to,
  input  logic [DIST_W-1:0]   in_edge_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] out_vertex,
  output logic [DIST_W-1:0]   out_distance,
  output logic                out_reached,
  output logic [VERTEX_W-1:0] out_predecessor,
  output logic                out_has_predecessor,
  output logic                out_is_destination,
  output logic                out_last
);

  localparam logic [DIST_W-1:0] INF_D = DIST_W'(INFINITE_DISTANCE);
  localparam logic [VCNT_W-1:0] MAX_N = VCNT_W'(MAX_VERTICES);

  logic [DIST_W-1:0]   edge_mem [MAT_DEPTH];
  logic [MAT_DEPTH-1:0] edge_vld_r;
  logic [DIST_W-1:0]   rd_w_r;
  logic                rd_hit_r;

  logic [DIST_W-1:0]   dist_r [MAX_VERTICES];
  logic [VERTEX_W-1:0] pred_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pred_vld_r;
  logic [MAX_VERTICES-1:0] settled_r;

  logic [VERTEX_W-1:0] idx_r, pick_r, rel_idx_r;
  logic [DIST_W-1:0]   best_r;
  logic                found_r, rel_vld_r, out_valid_r;

  logic [VERTEX_W-1:0] out_vertex_r, out_pred_r;
  logic [DIST_W-1:0]   out_distance_r;
  logic                out_reached_r, out_has_pred_r, out_is_dest_r, out_last_r;

  logic [VCNT_W-1:0]   n_active;
  logic [VERTEX_W-1:0] rd_idx;
  logic [DIST_W-1:0]   dist_rd;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic                wr_en, clr_en, idx_last;
  logic                src_in_range;
  logic [DIST_W-1:0]   w_eff;
  logic [DIST_W:0]     sum;
  logic                relax_upd, scan_better;

  assign n_active = (cfg.vertex_count > MAX_N) ? MAX_N : cfg.vertex_count;
  assign idx_last = (VCNT_W'(idx_r) + VCNT_W'(1)) == n_active;
  assign src_in_range = VCNT_W'(cfg.source_vertex) < n_active;

  // The relax stage owns the table read port while its data is in flight.
  assign rd_idx  = rel_vld_r ? rel_idx_r : idx_r;
  assign dist_rd = dist_r[rd_idx];

  assign wr_addr = {in_edge_from, in_edge_to};
  assign rd_addr = {pick_r, idx_r};
  assign wr_en   = cmd.accept && (in_req_type == REQ_WRITE) &&
                   (VCNT_W'(in_edge_from) < n_active) && (VCNT_W'(in_edge_to) < n_active);
  assign clr_en  = cmd.accept && (in_req_type == REQ_CLEAR);

  assign w_eff     = rd_hit_r ? rd_w_r : '0;
  assign sum       = {1'b0, best_r} + {1'b0, w_eff};
  assign relax_upd = rel_vld_r && (w_eff != '0) && !settled_r[rel_idx_r] &&
                     (sum < {1'b0, dist_rd});
  assign scan_better = !settled_r[idx_r] && (dist_rd < best_r);

  assign status.run_req  = (in_req_type == REQ_RUN);
  assign status.n_zero   = (n_active == '0);
  assign status.idx_last = idx_last;
  assign status.found    = found_r;
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) edge_mem[wr_addr] <= in_edge_weight;
    rd_w_r <= edge_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_vld_r <= '0;
    end else if (clr_en) begin
      edge_vld_r <= '0;
    end else if (wr_en) begin
      edge_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_hit_r <= edge_vld_r[rd_addr];
    if (relax_upd) pred_r[rel_idx_r] <= pick_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_VERTICES; i++) dist_r[i] <= INF_D;
      settled_r   <= '0;
      pred_vld_r  <= '0;
      idx_r       <= '0;
      pick_r      <= '0;
      best_r      <= INF_D;
      found_r     <= 1'b0;
      rel_vld_r   <= 1'b0;
      rel_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rel_vld_r <= cmd.relax_issue;
      rel_idx_r <= idx_r;

      if (cmd.init) begin
        // Every distance starts unreachable except an in-range source at zero.
        for (int i = 0; i < MAX_VERTICES; i++) begin
          dist_r[i] <= (src_in_range && (VERTEX_W'(i) == cfg.source_vertex)) ? '0 : INF_D;
        end
        settled_r  <= '0;
        pred_vld_r <= '0;
      end else if (relax_upd) begin
        dist_r[rel_idx_r]     <= sum[DIST_W-1:0];
        pred_vld_r[rel_idx_r] <= 1'b1;
      end

      if (cmd.init || cmd.scan_start) begin
        idx_r   <= '0;
        best_r  <= INF_D;
        found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_better) begin
          best_r  <= dist_rd;
          pick_r  <= idx_r;
          found_r <= 1'b1;
        end
        idx_r <= idx_r + VERTEX_W'(1);
      end else if (cmd.eval) begin
        if (found_r) settled_r[pick_r] <= 1'b1;
        idx_r <= '0;
      end else if (cmd.relax_issue || cmd.out_load) begin
        idx_r <= idx_r + VERTEX_W'(1);
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vertex_r   <= idx_r;
      out_distance_r <= dist_rd;
      out_reached_r  <= dist_rd < INF_D;
      out_pred_r     <= pred_vld_r[idx_r] ? pred_r[idx_r] : '0;
      out_has_pred_r <= pred_vld_r[idx_r];
      out_is_dest_r  <= idx_r == cfg.destination_vertex;
      out_last_r     <= idx_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_vertex          = out_vertex_r;
  assign out_distance        = out_distance_r;
  assign out_reached         = out_reached_r;
  assign out_predecessor     = out_pred_r;
  assign out_has_predecessor = out_has_pred_r;
  assign out_is_destination  = out_is_dest_r;
  assign out_last            = out_last_r;

  a_dist_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    dist_rd <= INF_D)
    else $error("stored distance above the unreachable mark");

  a_pred_reached: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && pred_vld_r[idx_r] |-> dist_rd < INF_D)
    else $error("vertex with a predecessor reported as unreachable");

  a_source_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && (idx_r == cfg.source_vertex) |-> dist_rd == '0)
    else $error("source vertex reported with nonzero distance");

  a_relax_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    rel_vld_r |-> $past(cmd.relax_issue))
    else $error("relax stage active without an issued weight read");

endmodule

>>> hdl/dijkstra_dense_shortest_path_top.sv
// Top level of the dense shortest path block: register port, controller and
// datapath. Depends on djk_pkg, djk_if, djk_ctrl and djk_dp.
//
//   Port    Direction  Carries
//   in_ch   sink       request: write edge, run, clear all edges
//   out_ch  source     one result per vertex in use after a run
//   cfg_ch  sink       register write: vertex count, source, destination
//
// Edge writes and clears are handled in the idle state, so while the block is idle
// those requests can stream at one transaction per clock. A run's compute time is
// set by the single table read port, walked once per vertex in every scan and
// relax pass, and each vertex in use then gets one result on the output channel.
// Reset clears the edge matrix at once through per-entry valid bits, so no
// clearing pass is needed. The result register lets a new request be taken while
// the final result of a run still waits; output stalls freeze the output walk.
module dijkstra_dense_shortest_path_top import djk_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  djk_in_if.sink   in_ch,
  djk_out_if.source out_ch,
  djk_cfg_if.sink  cfg_ch
);

  djk_cfg_t    cfg_r;
  djk_cmd_t    cmd;
  djk_status_t status;

  // Always writable; the user must write the block only while idle, unchecked.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertex_count       <= VCNT_W'(MAX_VERTICES);
      cfg_r.source_vertex      <= '0;
      cfg_r.destination_vertex <= '0;
    end else if (cfg_ch.valid) begin
      // Writes to an index beyond the register list are dropped.
      unique case (cfg_ch.index)
        CFG_VERTEX_COUNT: cfg_r.vertex_count       <= cfg_ch.data;
        CFG_SOURCE:       cfg_r.source_vertex      <= cfg_ch.data[VERTEX_W-1:0];
        CFG_DESTINATION:  cfg_r.destination_vertex <= cfg_ch.data[VERTEX_W-1:0];
        default: ;
      endcase
    end
  end

  djk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  djk_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg                 (cfg_r),
    .in_req_type         (in_ch.req_type),
    .in_edge_from        (in_ch.edge_from),
    .in_edge_to          (in_ch.edge_to),
    .in_edge_weight      (in_ch.edge_weight),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_vertex          (out_ch.vertex),
    .out_distance        (out_ch.distance),
    .out_reached         (out_ch.reached),
    .out_predecessor     (out_ch.predecessor),
    .out_has_predecessor (out_ch.has_predecessor),
    .out_is_destination  (out_ch.is_destination),
    .out_last            (out_ch.last)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the dense shortest path block (dijkstra_dense_shortest_path_top).
// Depends on djk_pkg for widths and codes and on djk_if for the three channel interfaces.
// A built-in path solver predicts every result; a single checker compares results in order.
module tb;
  import djk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The request code the block does not define. It must be accepted and dropped.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Stimulus sizes and time limits.
  localparam int RANDOM_ITEMS  = 190;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 700;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int REPORT_LIMIT  = 10;

  // Receiver behavior modes. Each one lasts for a random segment of cycles.
  typedef enum int {RX_FREE, RX_COIN, RX_LIGHT, RX_PERIODIC} rx_mode_t;

  // One result transaction, at the widths of the result channel.
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [DIST_W-1:0]   distance;
    logic                reached;
    logic [VERTEX_W-1:0] predecessor;
    logic                has_predecessor;
    logic                is_destination;
    logic                last;
  } vertex_result_t;

  logic clk;
  logic rst_n;

  djk_in_if  in_ch();
  djk_out_if out_ch();
  djk_cfg_if cfg_ch();

  dijkstra_dense_shortest_path_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the block's state: the weight matrix and the three registers.
  logic [DIST_W-1:0]   weight_mx [MAX_VERTICES][MAX_VERTICES];
  logic [VCNT_W-1:0]   shadow_vertex_count;
  logic [VERTEX_W-1:0] shadow_source;
  logic [VERTEX_W-1:0] shadow_destination;

  // Results that the solver has predicted and the block has not yet delivered.
  vertex_result_t pending_paths [$];

  int mismatch_count = 0;
  int useful_items;
  int cycle_count = 0;
  int hold_request;
  bit gaps_on;
  int burst_left;

  // The clock runs free with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost result ends the run here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Number of vertices that a run and an edge write work on. A vertex count above
  // the matrix size saturates, so a write of 17..31 behaves as sixteen.
  function automatic int unsigned active_vertices();
    return (shadow_vertex_count > MAX_VERTICES) ? MAX_VERTICES : shadow_vertex_count;
  endfunction

  // Dijkstra over the shadow matrix. Each round settles the lowest-index unsettled
  // vertex with the smallest distance below infinity, then relaxes its edges toward
  // unsettled vertices, taking a sum only when it is strictly smaller. Sums are kept
  // at full precision, so an oversized weight can never pull a distance past infinity.
  function automatic void solve_shortest_paths();
    int unsigned         n;
    int unsigned         path_len [MAX_VERTICES];
    logic [VERTEX_W-1:0] prev [MAX_VERTICES];
    bit                  prev_ok [MAX_VERTICES];
    bit                  settled [MAX_VERTICES];
    int unsigned         best;
    int unsigned         pick;
    int unsigned         sum;
    bit                  found;
    vertex_result_t      res;
    n = active_vertices();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      path_len[i] = INFINITE_DISTANCE;
      prev[i]     = '0;
      prev_ok[i]  = 1'b0;
      settled[i]  = 1'b0;
    end
    if (shadow_source < n) path_len[shadow_source] = 0;
    while (1) begin
      best  = INFINITE_DISTANCE;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!settled[i] && path_len[i] < best) begin
          best  = path_len[i];
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      settled[pick] = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (weight_mx[pick][i] != 0 && !settled[i]) begin
          sum = path_len[pick] + weight_mx[pick][i];
          if (sum < path_len[i]) begin
            path_len[i] = sum;
            prev[i]     = pick[VERTEX_W-1:0];
            prev_ok[i]  = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      res.vertex          = i[VERTEX_W-1:0];
      res.distance        = path_len[i][DIST_W-1:0];
      res.reached         = (path_len[i] < INFINITE_DISTANCE);
      res.predecessor     = prev_ok[i] ? prev[i] : '0;
      res.has_predecessor = prev_ok[i];
      res.is_destination  = (i == shadow_destination);
      res.last            = (i + 1 == n);
      pending_paths.push_back(res);
    end
  endfunction

  // Applies one accepted request transaction to the shadow state.
  function automatic void apply_request(input logic [REQ_W-1:0] req,
                                        input logic [VERTEX_W-1:0] from,
                                        input logic [VERTEX_W-1:0] to,
                                        input logic [DIST_W-1:0] weight);
    int unsigned n;
    n = active_vertices();
    case (req)
      REQ_WRITE: begin
        if (from < n && to < n) begin
          weight_mx[from][to] = weight;
          useful_items++;
        end
      end
      REQ_RUN: begin
        solve_shortest_paths();
        useful_items++;
      end
      REQ_CLEAR: begin
        foreach (weight_mx[i, j]) weight_mx[i][j] = '0;
        useful_items++;
      end
      default: ;
    endcase
  endfunction

  // Result checker. Every result transaction is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    vertex_result_t seen;
    vertex_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.vertex          = out_ch.vertex;
      seen.distance        = out_ch.distance;
      seen.reached         = out_ch.reached;
      seen.predecessor     = out_ch.predecessor;
      seen.has_predecessor = out_ch.has_predecessor;
      seen.is_destination  = out_ch.is_destination;
      seen.last            = out_ch.last;
      if (pending_paths.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result: vertex %0d distance %0d", $realtime,
                   seen.vertex, seen.distance);
      end else begin
        want = pending_paths.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected: v=%0d dist=%0d reached=%0b pred=%0d has_pred=%0b dst=%0b last=%0b",
                     want.vertex, want.distance, want.reached, want.predecessor,
                     want.has_predecessor, want.is_destination, want.last);
            $display("  actual:   v=%0d dist=%0d reached=%0b pred=%0d has_pred=%0b dst=%0b last=%0b",
                     seen.vertex, seen.distance, seen.reached, seen.predecessor,
                     seen.has_predecessor, seen.is_destination, seen.last);
          end
        end
      end
    end
  end

  // Receiver. It switches between free flow, coin-flip stalls, light stalls and a
  // periodic pattern, in random segments. Each new hold-off request from the stimulus
  // side overrides the pattern and keeps ready low until that hold-off has run out.
  initial begin : receiver_pacing
    int unsigned segment_left;
    int unsigned hold_left;
    int unsigned phase;
    int          hold_seen;
    rx_mode_t    mode;
    out_ch.ready = 1'b0;
    segment_left = 0;
    hold_left    = 0;
    phase        = 0;
    hold_seen    = 0;
    mode         = RX_FREE;
    forever begin
      @(negedge clk);
      if (hold_request != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_request;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (segment_left == 0) begin
          mode         = rx_mode_t'($urandom_range(0, 3));
          segment_left = $urandom_range(10, 120);
        end
        segment_left--;
        phase++;
        case (mode)
          RX_FREE:     out_ch.ready <= 1'b1;
          RX_COIN:     out_ch.ready <= ($urandom_range(0, 1) != 0);
          RX_LIGHT:    out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_ch.ready <= ((phase % 5) >= 2);
          default:     out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Sender pacing. Transactions go out in bursts of random length; between bursts
  // valid drops for a short gap or, now and then, a long one.
  task automatic pace_sender();
    int gap;
    if (!gaps_on) return;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 5);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Offers one request transaction and waits until the block accepts it. Valid is
  // left high on return unless pacing opens a gap, so back-to-back sends keep it asserted.
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [VERTEX_W-1:0] from,
                              input logic [VERTEX_W-1:0] to,
                              input logic [DIST_W-1:0] weight);
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.edge_from   <= from;
    in_ch.edge_to     <= to;
    in_ch.edge_weight <= weight;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(req, from, to, weight);
    pace_sender();
  endtask

  // Stops offering requests, waits for every predicted result, then lets the block
  // finish any trailing edge write, clear or empty run that leaves no trace.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transaction. Only called while the block is idle.
  task automatic write_register(input djk_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_VERTEX_COUNT: shadow_vertex_count = value;
      CFG_SOURCE:       shadow_source       = value[VERTEX_W-1:0];
      CFG_DESTINATION:  shadow_destination  = value[VERTEX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Weight mix: mostly short edges so that paths compete, plus removals, any legal weight,
  // weights at the top of the legal range and weights past it.
  function automatic logic [DIST_W-1:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return DIST_W'($urandom_range(1, 40));
    if (roll < 14) return '0;
    if (roll < 16) return DIST_W'($urandom_range(1, 9998));
    if (roll < 18) return DIST_W'($urandom_range(9990, 9998));
    return DIST_W'($urandom_range(0, 16383));
  endfunction

  // A vertex in use, or any vertex when none is in use.
  function automatic logic [VERTEX_W-1:0] pick_vertex();
    int unsigned n;
    n = active_vertices();
    return (n > 0) ? VERTEX_W'($urandom_range(0, n - 1))
                   : VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
  endfunction

  // Right after reset the matrix is empty and the registers hold their defaults, so
  // only vertex 0 is reached, out of sixteen results.
  task automatic test_reset_state();
    send_request(REQ_RUN, '0, '0, '0);
  endtask

  // Weight corners on the default sixteen vertices: the smallest and largest legal
  // weights, a weight past the legal range, a path that sums exactly to infinity, a
  // tie that must keep the first predecessor, an edge removed by a zero weight, the
  // highest vertex on both ends, a self loop and the unused request code. A clear
  // then wipes everything again.
  task automatic test_weight_corners();
    send_request(REQ_WRITE, 4'd0, 4'd1, 14'd1);
    send_request(REQ_WRITE, 4'd1, 4'd3, 14'd9998);
    send_request(REQ_WRITE, 4'd0, 4'd2, 14'h3FFF);
    send_request(REQ_WRITE, 4'd0, 4'd4, 14'd5);
    send_request(REQ_WRITE, 4'd0, 4'd5, 14'd3);
    send_request(REQ_WRITE, 4'd5, 4'd4, 14'd2);
    send_request(REQ_WRITE, 4'd0, 4'd6, 14'd8);
    send_request(REQ_WRITE, 4'd0, 4'd6, 14'd0);
    send_request(REQ_WRITE, 4'd4, 4'd15, 14'd1);
    send_request(REQ_WRITE, 4'd15, 4'd15, 14'd4);
    send_request(REQ_WRITE, 4'd15, 4'd7, 14'd2);
    send_request(REQ_UNUSED, 4'd15, 4'd15, 14'h3FFF);
    send_request(REQ_RUN, '0, '0, '0);
    send_request(REQ_CLEAR, '0, '0, '0);
    send_request(REQ_RUN, '0, '0, '0);
  endtask

  // Register corners: no vertices at all, a saturating vertex count, a source past
  // the vertices in use, edge writes past them, a single vertex, a masked source
  // value and the highest destination.
  task automatic test_register_corners();
    settle_block();
    write_register(CFG_VERTEX_COUNT, 5'd0);
    send_request(REQ_RUN, '0, '0, '0);
    settle_block();
    write_register(CFG_VERTEX_COUNT, 5'd31);
    write_register(CFG_DESTINATION, 5'd15);
    send_request(REQ_WRITE, 4'd0, 4'd9, 14'd12);
    send_request(REQ_RUN, '0, '0, '0);
    settle_block();
    write_register(CFG_VERTEX_COUNT, 5'd4);
    write_register(CFG_SOURCE, 5'd9);
    send_request(REQ_WRITE, 4'd5, 4'd1, 14'd3);
    send_request(REQ_WRITE, 4'd1, 4'd5, 14'd3);
    send_request(REQ_RUN, '0, '0, '0);
    settle_block();
    write_register(CFG_VERTEX_COUNT, 5'd16);
    write_register(CFG_SOURCE, 5'b1_0101);
    send_request(REQ_RUN, '0, '0, '0);
    settle_block();
    write_register(CFG_VERTEX_COUNT, 5'd1);
    write_register(CFG_SOURCE, 5'd0);
    write_register(CFG_DESTINATION, 5'd0);
    send_request(REQ_RUN, '0, '0, '0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering runs, each
  // followed by an edge write, so that the result path backs up and the request input stalls.
  task automatic test_output_backpressure();
    settle_block();
    write_register(CFG_VERTEX_COUNT, 5'd6);
    write_register(CFG_SOURCE, 5'd0);
    write_register(CFG_DESTINATION, 5'd5);
    gaps_on = 1'b0;
    send_request(REQ_CLEAR, '0, '0, '0);
    for (int i = 0; i < 5; i++)
      send_request(REQ_WRITE, i[VERTEX_W-1:0], VERTEX_W'(i + 1), DIST_W'(i + 1));
    send_request(REQ_WRITE, 4'd0, 4'd5, 14'd100);
    hold_request++;
    repeat (4) begin
      send_request(REQ_RUN, '0, '0, '0);
      send_request(REQ_WRITE, pick_vertex(), pick_vertex(), pick_weight());
    end
    gaps_on = 1'b1;
  endtask

  // The sender stops and waits until every predicted result has arrived, then runs
  // again on the same graph.
  task automatic test_drain_pause();
    repeat (3) send_request(REQ_WRITE, pick_vertex(), pick_vertex(), pick_weight());
    send_request(REQ_RUN, '0, '0, '0);
    settle_block();
    send_request(REQ_RUN, '0, '0, '0);
  endtask

  // Random graphs. Each phase picks a vertex count (mostly small, sometimes sixteen,
  // zero or saturating), a source and a destination, optionally clears the matrix and
  // then builds edges and runs one to three times. About one edge transaction in ten
  // is noise: any request code, any vertices, any weight.
  task automatic test_random_graphs();
    int unsigned         kind;
    int unsigned         n;
    int unsigned         edges;
    int                  stop_at;
    logic [VCNT_W-1:0]   count;
    logic [CFG_DATA_W-1:0] source_data;
    stop_at = useful_items + RANDOM_ITEMS;
    while (useful_items < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) count = 5'd0;
      else if (kind == 1) count = VCNT_W'($urandom_range(17, 31));
      else if (kind < 5) count = 5'd16;
      else count = VCNT_W'($urandom_range(1, 8));
      n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
      if ($urandom_range(0, 7) == 0 || n == 0)
        source_data = CFG_DATA_W'($urandom_range(0, 31));
      else
        source_data = CFG_DATA_W'($urandom_range(0, n - 1));
      settle_block();
      write_register(CFG_VERTEX_COUNT, count);
      write_register(CFG_SOURCE, source_data);
      write_register(CFG_DESTINATION, CFG_DATA_W'($urandom_range(0, 31)));
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) send_request(REQ_CLEAR, pick_vertex(), pick_vertex(), '0);
      repeat ($urandom_range(1, 3)) begin
        edges = $urandom_range(n, 3 * n + 2);
        repeat (edges) begin
          if ($urandom_range(0, 9) == 0)
            send_request(REQ_W'($urandom_range(0, 3)), VERTEX_W'($urandom_range(0, 15)),
                         VERTEX_W'($urandom_range(0, 15)), DIST_W'($urandom_range(0, 16383)));
          else
            send_request(REQ_WRITE, pick_vertex(), pick_vertex(), pick_weight());
        end
        send_request(REQ_RUN, pick_vertex(), pick_vertex(), pick_weight());
      end
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence: reset, the directed tests, the stall tests, the random graphs and
  // the final drain.
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_WRITE;
    in_ch.edge_from   = '0;
    in_ch.edge_to     = '0;
    in_ch.edge_weight = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_VERTEX_COUNT;
    cfg_ch.data       = '0;
    useful_items      = 0;
    hold_request      = 0;
    gaps_on           = 1'b1;
    burst_left        = 4;

    // Shadow state matches the block's reset: empty matrix, sixteen vertices, both
    // source and destination on vertex 0.
    foreach (weight_mx[i, j]) weight_mx[i][j] = '0;
    shadow_vertex_count = 5'd16;
    shadow_source       = '0;
    shadow_destination  = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_weight_corners();
    test_register_corners();
    test_output_backpressure();
    test_drain_pause();
    test_random_graphs();

    // Wait for every outstanding result, then give the block time to show any
    // result it should not produce.
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_paths.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
